// File: hw/rtl/ciex_pkg.sv
// Shared types, operation codes and constants of the integer execute unit.
`default_nettype none
package ciex_pkg;
  localparam int DEF_NUM_REGS = 16;
  localparam logic [31:0] WORD_MASK = 32'hFFFF_FFFF;
  localparam logic [7:0] SAR_BYTE_MASK = 8'b0000_0011;

  typedef enum logic [5:0] {
    OP_ABS = 6'd0, OP_ADD = 6'd1, OP_ADDI = 6'd2, OP_ADDX2 = 6'd3, OP_ADDX4 = 6'd4,
    OP_ADDX8 = 6'd5, OP_SUB = 6'd6, OP_AND = 6'd7, OP_OR = 6'd8, OP_XOR = 6'd9,
    OP_MOV = 6'd10, OP_MOVI = 6'd11, OP_MOVEQZ = 6'd12, OP_MOVNEZ = 6'd13,
    OP_MUL16S = 6'd14, OP_MUL16U = 6'd15, OP_MULL = 6'd16, OP_NSAU = 6'd17,
    OP_EXTUI = 6'd18, OP_SRLI = 6'd19, OP_SLLI = 6'd20, OP_SLL = 6'd21, OP_SRL = 6'd22,
    OP_SSL = 6'd23, OP_SSR = 6'd24, OP_SSA8L = 6'd25, OP_RSIL = 6'd26,
    OP_BEQ = 6'd27, OP_BEQI = 6'd28, OP_BEQZ = 6'd29, OP_BGEU = 6'd30,
    OP_BGEUI = 6'd31, OP_BGEZ = 6'd32, OP_BLT = 6'd33, OP_BLTU = 6'd34,
    OP_BLTUI = 6'd35, OP_BLTZ = 6'd36, OP_BNEI = 6'd37, OP_BNEZ = 6'd38,
    OP_BALL = 6'd39, OP_BANY = 6'd40, OP_CALL0 = 6'd41, OP_CALLX0 = 6'd42,
    OP_JUMP = 6'd43, OP_RET = 6'd44
  } op_t;

  // One unpacked instruction as it travels from the front to the back.
  typedef struct packed {
    logic [5:0]  op;
    logic [3:0]  r;
    logic [3:0]  s;
    logic [3:0]  t;
    logic [31:0] imm;
    logic [31:0] target;
    logic [31:0] npc;
    logic [4:0]  sc;
    logic [4:0]  fw;
  } instr_t;

  typedef struct packed {
    logic [31:0] pc;
    logic        taken;
    logic        wr;
    logic [3:0]  widx;
    logic [31:0] val;
  } result_t;
endpackage
`default_nettype wire

// File: hw/rtl/core_integer_execute_unit_top.sv
// Top level of the integer execute unit: stream ports, queue and execute back end.
// Path: an accepted item is written into the queue and then into the execute output register,
// from which it is presented on the output and held until out_tready takes it.
// Throughput: one item per cycle unless out_tready stalls; the execute logic is combinational.
// Reset (rst_n low, synchronous) empties the queue and output register and clears
// the register file, SAR and PS to zero.
`default_nettype none
module core_integer_execute_unit_top
  import ciex_pkg::*;
#(
  parameter int NUM_REGS = DEF_NUM_REGS
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  // From bit 0 up: op[5:0], dest_index[9:6], src_s_index[13:10], src_t_index[17:14],
  // immediate[49:18], target_addr[81:50], next_pc[113:82], shift_count[118:114],
  // field_width[123:119], zero fill [127:124].
  input  wire logic [127:0] in_tdata,
  output logic              out_tvalid,
  input  wire logic         out_tready,
  // From bit 0 up: pc_out[31:0], taken[32], reg_written[33], write_index[37:34],
  // write_value[69:38], zero fill [71:70].
  output logic [71:0]       out_tdata
);
  instr_t  in_i, q_head;
  logic    q_full, q_empty, q_pop, push;
  result_t res;

  // The front end only unpacks fields; classification happens by op code in the back.
  assign in_i.op     = in_tdata[5:0];
  assign in_i.r      = in_tdata[9:6];
  assign in_i.s      = in_tdata[13:10];
  assign in_i.t      = in_tdata[17:14];
  assign in_i.imm    = in_tdata[49:18];
  assign in_i.target = in_tdata[81:50];
  assign in_i.npc    = in_tdata[113:82];
  assign in_i.sc     = in_tdata[118:114];
  assign in_i.fw     = in_tdata[123:119];

  // The queue is ready while it has a free slot, independent of the output side.
  assign in_tready = !q_full;
  assign push = in_tvalid && !q_full;

  ciex_queue u_queue (
    .clk(clk), .rst_n(rst_n), .push(push), .push_data(in_i),
    .full(q_full), .empty(q_empty), .pop(q_pop), .head(q_head)
  );

  ciex_back #(.NUM_REGS(NUM_REGS)) u_back (
    .clk(clk), .rst_n(rst_n), .q_empty(q_empty), .q_head(q_head), .q_pop(q_pop),
    .out_valid(out_tvalid), .out_ready(out_tready), .out_res(res)
  );

  assign out_tdata = {2'b00, res.val, res.widx, res.wr, res.taken, res.pc};
endmodule
`default_nettype wire

// File: hw/rtl/ciex_queue.sv
// Two-entry queue that decouples the front end from the execute back end.
`default_nettype none
module ciex_queue
  import ciex_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  wire logic   push,
  input  wire instr_t push_data,
  output logic        full,
  output logic        empty,
  input  wire logic   pop,
  output instr_t      head
);
  instr_t     mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;

  assign full  = cnt_r == 2'd2;
  assign empty = cnt_r == 2'd0;
  assign head  = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0;
      rp_r <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= push_data;
  end
endmodule
`default_nettype wire

// File: hw/rtl/ciex_back.sv
// Execute back end: register file, SAR, PS and combinational ALU/branch with output register.
`default_nettype none
module ciex_back
  import ciex_pkg::*;
#(
  parameter int NUM_REGS = DEF_NUM_REGS
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  wire logic   q_empty,
  input  wire instr_t q_head,
  output logic        q_pop,
  output logic        out_valid,
  input  wire logic   out_ready,
  output result_t     out_res
);
  localparam int IW = $clog2(NUM_REGS);

  logic [31:0] rf_r [NUM_REGS];
  logic [5:0]  sar_r, sar_nxt;
  logic [31:0] ps_r, ps_nxt;
  logic        ov_r;
  result_t     res_r, res_nxt;
  logic [31:0] as, at, a0, val, b;
  logic [63:0] shl64;
  logic [5:0]  nz;
  logic        wr, tk, cond, br;
  logic [IW-1:0] widx;
  instr_t      i;

  assign i  = q_head;
  assign as = rf_r[i.s[IW-1:0]];
  assign at = rf_r[i.t[IW-1:0]];
  assign a0 = rf_r[0];
  assign q_pop = !q_empty && (!ov_r || out_ready);
  assign out_valid = ov_r;
  assign out_res = res_r;

  always_comb begin
    nz = 6'd32;
    for (int k = 0; k < 32; k++) begin
      if (as[k]) nz = 6'(31 - k);
    end
  end

  always_comb begin
    val = '0; wr = 1'b0; tk = 1'b0; cond = 1'b0; br = 1'b0;
    b = i.imm; sar_nxt = sar_r; ps_nxt = ps_r;
    widx = i.r[IW-1:0];
    shl64 = {as, 32'd0} >> sar_r;
    res_nxt.pc = i.npc;
    case (op_t'(i.op))
      OP_ABS:    begin val = at[31] ? 32'd0 - at : at; wr = 1'b1; end
      OP_ADD:    begin val = as + at; wr = 1'b1; end
      OP_ADDI:   begin val = as + i.imm; wr = 1'b1; end
      OP_ADDX2:  begin val = {as[30:0], 1'b0} + at; wr = 1'b1; end
      OP_ADDX4:  begin val = {as[29:0], 2'b0} + at; wr = 1'b1; end
      OP_ADDX8:  begin val = {as[28:0], 3'b0} + at; wr = 1'b1; end
      OP_SUB:    begin val = as - at; wr = 1'b1; end
      OP_AND:    begin val = as & at; wr = 1'b1; end
      OP_OR:     begin val = as | at; wr = 1'b1; end
      OP_XOR:    begin val = as ^ at; wr = 1'b1; end
      OP_MOV:    begin val = as; wr = 1'b1; end
      OP_MOVI:   begin val = i.imm; wr = 1'b1; end
      OP_MOVEQZ: begin val = as; wr = (at == 32'd0); end
      OP_MOVNEZ: begin val = as; wr = (at != 32'd0); end
      OP_MUL16S: begin
        val = 32'($signed(as[15:0]) * $signed(at[15:0])); wr = 1'b1;
      end
      OP_MUL16U: begin val = 32'(as[15:0]) * 32'(at[15:0]); wr = 1'b1; end
      OP_MULL:   begin val = as * at; wr = 1'b1; end
      OP_NSAU:   begin val = 32'(nz); wr = 1'b1; end
      OP_EXTUI:  begin
        val = (at >> i.sc) & 32'((33'd1 << i.fw) - 33'd1); wr = 1'b1;
      end
      OP_SRLI:   begin val = at >> i.sc; wr = 1'b1; end
      OP_SLLI:   begin val = as << i.sc; wr = 1'b1; end
      OP_SLL:    begin val = shl64[31:0]; wr = 1'b1; end
      OP_SRL:    begin val = sar_r[5] ? 32'd0 : at >> sar_r[4:0]; wr = 1'b1; end
      OP_SSL:    sar_nxt = 6'd32 - {1'b0, as[4:0]};
      OP_SSR:    sar_nxt = {1'b0, as[4:0]};
      OP_SSA8L:  sar_nxt = {1'b0, as[1:0] & SAR_BYTE_MASK[1:0], 3'b000};
      OP_RSIL:   begin val = ps_r; wr = 1'b1; ps_nxt = {ps_r[31:4], i.imm[3:0]}; end
      OP_BEQ:    begin br = 1'b1; cond = as == at; end
      OP_BEQI:   begin br = 1'b1; cond = as == b; end
      OP_BEQZ:   begin br = 1'b1; cond = as == 32'd0; end
      OP_BGEU:   begin br = 1'b1; cond = as >= at; end
      OP_BGEUI:  begin br = 1'b1; cond = as >= b; end
      OP_BGEZ:   begin br = 1'b1; cond = !as[31]; end
      OP_BLT:    begin br = 1'b1; cond = $signed(as) < $signed(at); end
      OP_BLTU:   begin br = 1'b1; cond = as < at; end
      OP_BLTUI:  begin br = 1'b1; cond = as < b; end
      OP_BLTZ:   begin br = 1'b1; cond = as[31]; end
      OP_BNEI:   begin br = 1'b1; cond = as != b; end
      OP_BNEZ:   begin br = 1'b1; cond = as != 32'd0; end
      OP_BALL:   begin br = 1'b1; cond = (~as & at) == 32'd0; end
      OP_BANY:   begin br = 1'b1; cond = (as & at) != 32'd0; end
      OP_CALL0:  begin
        res_nxt.pc = i.target; tk = 1'b1; val = i.npc; widx = '0; wr = 1'b1;
      end
      OP_CALLX0: begin
        res_nxt.pc = as; tk = 1'b1; val = i.npc; widx = '0; wr = 1'b1;
      end
      OP_JUMP:   begin res_nxt.pc = i.target; tk = 1'b1; end
      OP_RET:    begin res_nxt.pc = a0; tk = 1'b1; end
      default:   ;
    endcase
    if (br && cond) begin
      res_nxt.pc = i.target;
      tk = 1'b1;
    end
    res_nxt.taken = tk;
    res_nxt.wr    = wr;
    res_nxt.widx  = wr ? 4'(widx) : 4'd0;
    res_nxt.val   = wr ? val : 32'd0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r  <= 1'b0;
      sar_r <= '0;
      ps_r  <= '0;
      for (int k = 0; k < NUM_REGS; k++) rf_r[k] <= '0;
    end else begin
      if (q_pop) begin
        ov_r  <= 1'b1;
        sar_r <= sar_nxt;
        ps_r  <= ps_nxt;
        if (wr) rf_r[widx] <= val;
      end else if (out_ready) begin
        ov_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) res_r <= res_nxt;
  end
endmodule
`default_nettype wire
